// ===== sv/clrp_pkg.sv =====
// ---------------------------------------------------------------------------
// clrp_pkg
// shared types and constants of the cluster load rebalance planner
// ---------------------------------------------------------------------------
package clrp_pkg;

  localparam int ID_W     = 16;
  localparam int LEAD_W   = 12;
  localparam int DATA_W   = 48;
  localparam int RATE_W   = 32;
  localparam int SUM_W    = 56;
  localparam int CNT_W    = 9;
  localparam int RATIO_W  = 16;
  localparam int PROD_W   = 64;
  localparam int TASK_CAP = 8;
  localparam int CAP_W    = 4;

  localparam logic [1:0] METRIC_NONE = 2'd0;
  localparam logic [1:0] METRIC_LEAD = 2'd1;
  localparam logic [1:0] METRIC_DATA = 2'd2;
  localparam logic [1:0] METRIC_RATE = 2'd3;

  localparam logic [1:0] REG_SPREAD = 2'd0;
  localparam logic [1:0] REG_RATIO  = 2'd1;
  localparam logic [1:0] REG_FLOOR  = 2'd2;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_TASK    = 1'b1;
  localparam logic TASK_MIGRATE = 1'b0;
  localparam logic TASK_LEADER  = 1'b1;

  typedef struct packed {
    logic [LEAD_W-1:0]  spread;
    logic [RATIO_W-1:0] ratio;
    logic [15:0]        floor_rate;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [LEAD_W-1:0] lead_min;
    logic [LEAD_W-1:0] lead_max;
    logic [SUM_W-1:0]  data_sum;
    logic [DATA_W-1:0] data_min;
    logic [DATA_W-1:0] data_max;
    logic [SUM_W-1:0]  rate_sum;
    logic [RATE_W-1:0] rate_min;
    logic [RATE_W-1:0] rate_max;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    logic [RATE_W-1:0] rate;
  } wr_t;

  typedef struct packed {
    logic            kind;
    logic            need;
    logic [1:0]      metric;
    logic            tkind;
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] dst;
    logic            last;
  } out_t;

endpackage

// ===== sv/clrp_front.sv =====
// ---------------------------------------------------------------------------
// clrp_front
// accepts node records, keeps running min, max and sum, hands off a job
// ---------------------------------------------------------------------------
module clrp_front #(
  parameter int MAX_NODES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [clrp_pkg::ID_W-1:0]        node_ident,
  input  logic [clrp_pkg::LEAD_W-1:0]      leaders_held,
  input  logic [clrp_pkg::DATA_W-1:0]      stored_bytes,
  input  logic [clrp_pkg::RATE_W-1:0]      query_rate,
  input  logic                             final_node,
  output clrp_pkg::wr_t                    wr,
  output logic [$clog2(MAX_NODES)-1:0]     wr_addr,
  output logic                             job_push,
  output clrp_pkg::job_t                   job,
  input  logic                             done
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(MAX_NODES);

  logic                          busy;
  logic [CW-1:0]                 tally, tally_next;
  logic [clrp_pkg::LEAD_W-1:0]   lead_min, lead_max, lead_min_next, lead_max_next;
  logic [clrp_pkg::SUM_W-1:0]    data_sum, rate_sum, data_sum_next, rate_sum_next;
  logic [clrp_pkg::DATA_W-1:0]   data_min, data_max, data_min_next, data_max_next;
  logic [clrp_pkg::RATE_W-1:0]   rate_min, rate_max, rate_min_next, rate_max_next;
  logic                          acc, room;

  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;
  assign room     = tally < CW'(MAX_NODES);

  always_comb begin
    tally_next    = tally;
    lead_min_next = lead_min;
    lead_max_next = lead_max;
    data_sum_next = data_sum;
    data_min_next = data_min;
    data_max_next = data_max;
    rate_sum_next = rate_sum;
    rate_min_next = rate_min;
    rate_max_next = rate_max;
    if (room) begin
      tally_next    = tally + CW'(1);
      lead_min_next = (leaders_held < lead_min) ? leaders_held : lead_min;
      lead_max_next = (leaders_held > lead_max) ? leaders_held : lead_max;
      data_sum_next = data_sum + clrp_pkg::SUM_W'(stored_bytes);
      data_min_next = (stored_bytes < data_min) ? stored_bytes : data_min;
      data_max_next = (stored_bytes > data_max) ? stored_bytes : data_max;
      rate_sum_next = rate_sum + clrp_pkg::SUM_W'(query_rate);
      rate_min_next = (query_rate < rate_min) ? query_rate : rate_min;
      rate_max_next = (query_rate > rate_max) ? query_rate : rate_max;
    end
  end

  assign wr.en    = acc && room;
  assign wr.id    = node_ident;
  assign wr.data  = stored_bytes;
  assign wr.rate  = query_rate;
  assign wr_addr  = tally[AW-1:0];

  assign job_push      = acc && final_node;
  assign job.n         = clrp_pkg::CNT_W'(tally_next);
  assign job.lead_min  = lead_min_next;
  assign job.lead_max  = lead_max_next;
  assign job.data_sum  = data_sum_next;
  assign job.data_min  = data_min_next;
  assign job.data_max  = data_max_next;
  assign job.rate_sum  = rate_sum_next;
  assign job.rate_min  = rate_min_next;
  assign job.rate_max  = rate_max_next;

  always_ff @(posedge clk) begin
    if (rst || (acc && final_node)) begin
      tally    <= '0;
      lead_min <= '1;
      lead_max <= '0;
      data_sum <= '0;
      data_min <= '1;
      data_max <= '0;
      rate_sum <= '0;
      rate_min <= '1;
      rate_max <= '0;
    end else if (acc) begin
      tally    <= tally_next;
      lead_min <= lead_min_next;
      lead_max <= lead_max_next;
      data_sum <= data_sum_next;
      data_min <= data_min_next;
      data_max <= data_max_next;
      rate_sum <= rate_sum_next;
      rate_min <= rate_min_next;
      rate_max <= rate_max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (acc && final_node) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

endmodule

// ===== sv/clrp_queue.sv =====
// ---------------------------------------------------------------------------
// clrp_queue
// two-entry queue of finished reports between front and planner
// ---------------------------------------------------------------------------
module clrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clrp_pkg::job_t din,
  input  logic           pop,
  output clrp_pkg::job_t dout,
  output logic           empty
);

  clrp_pkg::job_t mem [2];
  logic           wptr, rptr;
  logic [1:0]     count;

  assign empty = (count == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && count != 2'd2) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && count != 2'd2) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((push && count != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== sv/clrp_back.sv =====
// ---------------------------------------------------------------------------
// clrp_back
// planner: imbalance tests, average, node classification and pairing
// ---------------------------------------------------------------------------
module clrp_back #(
  parameter int MAX_NODES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  clrp_pkg::cfg_t               cfg,
  input  clrp_pkg::wr_t                wr,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic                         job_ready,
  input  clrp_pkg::job_t               job,
  output logic                         job_pop,
  output logic                         done,
  output logic                         out_valid,
  input  logic                         out_stall,
  output clrp_pkg::out_t               out_q
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = clrp_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LEAD, S_MUL, S_DTEST, S_RTEST, S_DIV, S_AVG, S_THR,
    S_CRD, S_CCHK, S_CUND, S_SUM, S_TRDO, S_TRDU, S_TEMIT, S_DONE
  } state_t;

  state_t state, mul_ret;

  logic [clrp_pkg::ID_W-1:0]   id_mem   [MAX_NODES];
  logic [clrp_pkg::DATA_W-1:0] data_mem [MAX_NODES];
  logic [clrp_pkg::RATE_W-1:0] rate_mem [MAX_NODES];
  logic [clrp_pkg::ID_W-1:0]   rd_id;
  logic [clrp_pkg::DATA_W-1:0] rd_data;
  logic [clrp_pkg::RATE_W-1:0] rd_rate;
  logic [AW-1:0]               rd_addr;

  clrp_pkg::job_t              jq;
  logic [1:0]                  metric;
  logic [clrp_pkg::PROD_W-1:0] mc, prod, thr;
  logic [clrp_pkg::RATIO_W-1:0] mp;
  logic [3:0]                  mcnt;
  logic [clrp_pkg::SUM_W-1:0]  dvd;
  logic [CW-1:0]               rem;
  logic [CW:0]                 trial;
  logic [5:0]                  dcnt;
  logic [CW-1:0]               idx;
  logic [AW-1:0]               heavy_list [clrp_pkg::TASK_CAP];
  logic [AW-1:0]               light_list [clrp_pkg::TASK_CAP];
  logic [clrp_pkg::CAP_W-1:0]  no, nu, pairs, k;
  logic [clrp_pkg::ID_W-1:0]   src;
  logic [clrp_pkg::DATA_W-1:0] rd_val;
  logic                        slot_free;
  logic                        emit;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = slot_free && ((state == S_SUM) || (state == S_TEMIT));
  assign pairs     = (no < nu) ? no : nu;
  assign rd_val    = (metric == clrp_pkg::METRIC_DATA) ? rd_data
                                                       : clrp_pkg::DATA_W'(rd_rate);
  assign trial     = {rem, dvd[clrp_pkg::SUM_W-1]};
  assign job_pop   = (state == S_IDLE) && job_ready;
  assign done      = (state == S_DONE);

  always_comb begin
    unique case (state)
      S_TRDO:         rd_addr = heavy_list[k[2:0]];
      S_TRDU, S_TEMIT: rd_addr = light_list[k[2:0]];
      default:        rd_addr = idx[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_mem[wr_addr]   <= wr.id;
      data_mem[wr_addr] <= wr.data;
      rate_mem[wr_addr] <= wr.rate;
    end
    rd_id   <= id_mem[rd_addr];
    rd_data <= data_mem[rd_addr];
    rd_rate <= rate_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_ret   <= S_IDLE;
      out_valid <= 1'b0;
      metric    <= clrp_pkg::METRIC_NONE;
      no        <= '0;
      nu        <= '0;
      k         <= '0;
      idx       <= '0;
      mcnt      <= '0;
      dcnt      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_ready) begin
            jq     <= job;
            metric <= clrp_pkg::METRIC_NONE;
            no     <= '0;
            nu     <= '0;
            k      <= '0;
            idx    <= '0;
            state  <= S_LEAD;
          end
        end
        S_LEAD: begin
          if (jq.n < CW'(2)) begin
            state <= S_SUM;
          end else if ((jq.lead_max - jq.lead_min) > cfg.spread) begin
            metric <= clrp_pkg::METRIC_LEAD;
            state  <= S_SUM;
          end else if (jq.data_min == '0) begin
            if (jq.data_max != '0) begin
              metric <= clrp_pkg::METRIC_DATA;
              dvd    <= jq.data_sum;
              rem    <= '0;
              dcnt   <= '0;
              state  <= S_DIV;
            end else begin
              mc      <= clrp_pkg::PROD_W'(jq.rate_min);
              mp      <= cfg.ratio;
              prod    <= '0;
              mcnt    <= '0;
              mul_ret <= S_RTEST;
              state   <= S_MUL;
            end
          end else begin
            mc      <= clrp_pkg::PROD_W'(jq.data_min);
            mp      <= cfg.ratio;
            prod    <= '0;
            mcnt    <= '0;
            mul_ret <= S_DTEST;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          if (mp[0]) begin
            prod <= prod + mc;
          end
          mc   <= mc << 1;
          mp   <= mp >> 1;
          mcnt <= mcnt + 4'd1;
          if (mcnt == 4'd15) begin
            state <= mul_ret;
          end
        end
        S_DTEST: begin
          if (clrp_pkg::PROD_W'({jq.data_max, 8'h00}) > prod) begin
            metric <= clrp_pkg::METRIC_DATA;
            dvd    <= jq.data_sum;
            rem    <= '0;
            dcnt   <= '0;
            state  <= S_DIV;
          end else begin
            mc      <= clrp_pkg::PROD_W'(jq.rate_min);
            mp      <= cfg.ratio;
            prod    <= '0;
            mcnt    <= '0;
            mul_ret <= S_RTEST;
            state   <= S_MUL;
          end
        end
        S_RTEST: begin
          if ((jq.rate_min == '0)
              ? (jq.rate_max > clrp_pkg::RATE_W'(cfg.floor_rate))
              : (clrp_pkg::PROD_W'({jq.rate_max, 8'h00}) > prod)) begin
            metric <= clrp_pkg::METRIC_RATE;
            dvd    <= jq.rate_sum;
            rem    <= '0;
            dcnt   <= '0;
            state  <= S_DIV;
          end else begin
            state <= S_SUM;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, jq.n}) begin
            rem <= CW'(trial - {1'b0, jq.n});
            dvd <= {dvd[clrp_pkg::SUM_W-2:0], 1'b1};
          end else begin
            rem <= trial[CW-1:0];
            dvd <= {dvd[clrp_pkg::SUM_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(clrp_pkg::SUM_W - 1)) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          if (dvd == '0) begin
            state <= S_SUM;
          end else begin
            mc      <= clrp_pkg::PROD_W'(dvd);
            mp      <= cfg.ratio;
            prod    <= '0;
            mcnt    <= '0;
            mul_ret <= S_THR;
            state   <= S_MUL;
          end
        end
        S_THR: begin
          thr   <= prod;
          idx   <= '0;
          state <= S_CRD;
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (clrp_pkg::PROD_W'({rd_val, 8'h00}) > thr) begin
            if (no != clrp_pkg::CAP_W'(clrp_pkg::TASK_CAP)) begin
              heavy_list[no[2:0]] <= idx[AW-1:0];
              no <= no + 4'd1;
            end
            idx   <= idx + CW'(1);
            state <= (idx + CW'(1) == jq.n) ? S_SUM : S_CRD;
          end else begin
            mc      <= clrp_pkg::PROD_W'(rd_val);
            mp      <= cfg.ratio;
            prod    <= '0;
            mcnt    <= '0;
            mul_ret <= S_CUND;
            state   <= S_MUL;
          end
        end
        S_CUND: begin
          if (prod < clrp_pkg::PROD_W'({dvd, 8'h00})) begin
            if (nu != clrp_pkg::CAP_W'(clrp_pkg::TASK_CAP)) begin
              light_list[nu[2:0]] <= idx[AW-1:0];
              nu <= nu + 4'd1;
            end
          end
          idx   <= idx + CW'(1);
          state <= (idx + CW'(1) == jq.n) ? S_SUM : S_CRD;
        end
        S_SUM: begin
          if (slot_free) begin
            out_q.kind    <= clrp_pkg::KIND_SUMMARY;
            out_q.need    <= (metric != clrp_pkg::METRIC_NONE);
            out_q.metric  <= metric;
            out_q.tkind   <= clrp_pkg::TASK_MIGRATE;
            out_q.src     <= '0;
            out_q.dst     <= '0;
            out_q.last    <= (pairs == '0);
            k             <= '0;
            state         <= (pairs == '0) ? S_DONE : S_TRDO;
          end
        end
        S_TRDO: begin
          state <= S_TRDU;
        end
        S_TRDU: begin
          src   <= rd_id;
          state <= S_TEMIT;
        end
        S_TEMIT: begin
          if (slot_free) begin
            out_q.kind   <= clrp_pkg::KIND_TASK;
            out_q.need   <= 1'b1;
            out_q.metric <= metric;
            out_q.tkind  <= (metric == clrp_pkg::METRIC_RATE) ? clrp_pkg::TASK_LEADER
                                                               : clrp_pkg::TASK_MIGRATE;
            out_q.src    <= src;
            out_q.dst    <= rd_id;
            out_q.last   <= (k + 4'd1 == pairs);
            k            <= k + 4'd1;
            state        <= (k + 4'd1 == pairs) ? S_DONE : S_TRDO;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/cluster_load_rebalance_planner_core.sv =====
// ---------------------------------------------------------------------------
// cluster_load_rebalance_planner_core
// node load collector and rebalance planner
// ---------------------------------------------------------------------------
// input channel: one node record per request (in_valid / in_stall); a record
//   that is taken updates stores and running statistics.
// a record with final_node set closes the report; in_stall then stays high
//   until the planner has issued the last result of that report.
// output channel: a summary item, then up to 8 task items, the last one
//   flagged by last_item; the planner holds a pending item in place while
//   out_stall is high.
// planning after the final record: ratio tests run on a 16-step shared
//   multiplier, the average on a bit-serial divider, then each node is
//   classified and each task is read and issued.
// config: cfg_we writes register cfg_index (0 leader spread limit, 1 ratio in
//   Q8.8, 2 idle rate floor); user must write only while idle (unenforced).
// reset: rst is synchronous; statistics clear, config returns to defaults,
//   no result is pending; node stores are not cleared.
// ---------------------------------------------------------------------------
module cluster_load_rebalance_planner_core #(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] node_ident,
  input  logic [11:0] leaders_held,
  input  logic [47:0] stored_bytes,
  input  logic [31:0] query_rate,
  input  logic        final_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic        rebalance_needed,
  output logic [1:0]  chosen_metric,
  output logic        task_kind,
  output logic [15:0] source_ident,
  output logic [15:0] target_ident,
  output logic        last_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  clrp_pkg::cfg_t               cfg;
  clrp_pkg::wr_t                wr;
  logic [$clog2(MAX_NODES)-1:0] wr_addr;
  logic                         job_push, job_pop, job_empty, done;
  clrp_pkg::job_t               job_in, job_out;
  clrp_pkg::out_t               out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spread     <= 12'd2;
      cfg.ratio      <= 16'd384;
      cfg.floor_rate <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clrp_pkg::REG_SPREAD: cfg.spread     <= cfg_data[11:0];
        clrp_pkg::REG_RATIO:  cfg.ratio      <= cfg_data;
        clrp_pkg::REG_FLOOR:  cfg.floor_rate <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  clrp_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .node_ident   (node_ident),
    .leaders_held (leaders_held),
    .stored_bytes (stored_bytes),
    .query_rate   (query_rate),
    .final_node   (final_node),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .job_push     (job_push),
    .job          (job_in),
    .done         (done)
  );

  clrp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  clrp_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .job_ready (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .done      (done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_q     (out_q)
  );

  assign item_kind        = out_q.kind;
  assign rebalance_needed = out_q.need;
  assign chosen_metric    = out_q.metric;
  assign task_kind        = out_q.tkind;
  assign source_ident     = out_q.src;
  assign target_ident     = out_q.dst;
  assign last_item        = out_q.last;

`ifndef NO_ASSERTIONS
  a_stall_after_final: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && final_node) |=> in_stall)
    else $error("input not held off after final record");

  a_summary_need: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == clrp_pkg::KIND_SUMMARY) |->
      (rebalance_needed == (chosen_metric != clrp_pkg::METRIC_NONE)))
    else $error("summary need flag disagrees with metric");

  a_task_metric: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind == clrp_pkg::KIND_TASK) |->
      (chosen_metric == clrp_pkg::METRIC_DATA || chosen_metric == clrp_pkg::METRIC_RATE))
    else $error("task item with a metric that plans no tasks");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for cluster_load_rebalance_planner_core
// ---------------------------------------------------------------------------
// Node reports are queued by an initial block and fed by a clocked driver.
// A predictor tracks the stores and running statistics of each report and
// works out the summary and the task items at each accepted final record.
// A monitor compares each result field by field with the oldest expected
// item. Phases change the config registers and the idle and stall rates.
// The receiver holds off once for a long stretch so that the block fills.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 16;
  localparam int LIMIT = 1000000;

  typedef struct packed {
    logic [15:0] ident;
    logic [11:0] leaders;
    logic [47:0] bytes;
    logic [31:0] rate;
    logic        fin;
  } record_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] node_ident = '0;
  logic [11:0] leaders_held = '0;
  logic [47:0] stored_bytes = '0;
  logic [31:0] query_rate = '0;
  logic        final_node = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        item_kind, rebalance_needed, task_kind, last_item;
  logic [1:0]  chosen_metric;
  logic [15:0] source_ident, target_ident;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cluster_load_rebalance_planner_core dut (.*);

  always #5 clk = ~clk;

  record_t        pending_records[$];
  clrp_pkg::out_t expected_items[$];
  int             idle_pct = 0, stall_pct = 0;
  int             fails = 0, cycles = 0, records_taken = 0;
  int             hold_cnt = 0;
  bit             hold_done = 0;

  // predictor state
  logic [11:0] spread_lim = 12'd2;
  logic [15:0] ratio = 16'd384;
  logic [15:0] floor_rate = 16'd100;
  logic [15:0] id_tab[NODES];
  logic [47:0] data_tab[NODES];
  logic [31:0] rate_tab[NODES];
  int          tally = 0;
  logic [11:0] lmin = '1, lmax = '0;
  logic [79:0] dsum = '0, rsum = '0;
  logic [47:0] dmin = '1, dmax = '0;
  logic [31:0] rmin = '1, rmax = '0;

  function automatic void add_record(record_t r);
    pending_records.insert(pending_records.size(), r);
  endfunction

  function automatic void add_expected(clrp_pkg::out_t it);
    expected_items.insert(expected_items.size(), it);
  endfunction

  function automatic bit ratio_holds(logic [79:0] mx, logic [79:0] mn, logic [79:0] zfloor);
    if (mn == 0) return mx > zfloor;
    return mx * 256 > mn * ratio;
  endfunction

  task automatic plan_record(record_t r);
    logic [1:0]     metric;
    logic [79:0]    avg, v;
    int             over[NODES], under[NODES];
    int             no, nu, pairs;
    clrp_pkg::out_t it;
    metric = clrp_pkg::METRIC_NONE;
    no = 0;
    nu = 0;
    if (tally < NODES) begin
      id_tab[tally] = r.ident;
      data_tab[tally] = r.bytes;
      rate_tab[tally] = r.rate;
      tally++;
      if (r.leaders < lmin) lmin = r.leaders;
      if (r.leaders > lmax) lmax = r.leaders;
      dsum += r.bytes;
      if (r.bytes < dmin) dmin = r.bytes;
      if (r.bytes > dmax) dmax = r.bytes;
      rsum += r.rate;
      if (r.rate < rmin) rmin = r.rate;
      if (r.rate > rmax) rmax = r.rate;
    end
    if (!r.fin) return;
    if (tally >= 2) begin
      if (lmax - lmin > spread_lim) metric = clrp_pkg::METRIC_LEAD;
      else if (ratio_holds(dmax, dmin, 0)) metric = clrp_pkg::METRIC_DATA;
      else if (ratio_holds(rmax, rmin, floor_rate)) metric = clrp_pkg::METRIC_RATE;
    end
    if (metric == clrp_pkg::METRIC_DATA || metric == clrp_pkg::METRIC_RATE) begin
      avg = ((metric == clrp_pkg::METRIC_DATA) ? dsum : rsum) / tally;
      if (avg > 0) begin
        for (int i = 0; i < tally; i++) begin
          v = (metric == clrp_pkg::METRIC_DATA) ? 80'(data_tab[i]) : 80'(rate_tab[i]);
          if (v * 256 > avg * ratio) over[no++] = i;
          else if (v * ratio < avg * 256) under[nu++] = i;
        end
      end
    end
    pairs = (no < nu) ? no : nu;
    if (pairs > clrp_pkg::TASK_CAP) pairs = clrp_pkg::TASK_CAP;
    it = '0;
    it.kind = clrp_pkg::KIND_SUMMARY;
    it.need = (metric != clrp_pkg::METRIC_NONE);
    it.metric = metric;
    it.last = (pairs == 0);
    add_expected(it);
    for (int i = 0; i < pairs; i++) begin
      it.kind = clrp_pkg::KIND_TASK;
      it.need = 1'b1;
      it.tkind = (metric == clrp_pkg::METRIC_RATE) ? clrp_pkg::TASK_LEADER
                                                   : clrp_pkg::TASK_MIGRATE;
      it.src = id_tab[over[i]];
      it.dst = id_tab[under[i]];
      it.last = (i + 1 == pairs);
      add_expected(it);
    end
    tally = 0;
    lmin = '1;
    lmax = '0;
    dsum = '0;
    rsum = '0;
    dmin = '1;
    dmax = '0;
    rmin = '1;
    rmax = '0;
  endtask

  // driver
  always @(posedge clk) begin
    record_t r;
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        plan_record({node_ident, leaders_held, stored_bytes, query_rate, final_node});
        records_taken <= records_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_records.size() > 0 && $urandom_range(99) >= idle_pct) begin
          r = pending_records.pop_front();
          node_ident <= r.ident;
          leaders_held <= r.leaders;
          stored_bytes <= r.bytes;
          query_rate <= r.rate;
          final_node <= r.fin;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (!hold_done && records_taken >= 60) begin
      hold_done <= 1;
      hold_cnt <= 400;
      out_stall <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    clrp_pkg::out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result item src %0d dst %0d", source_ident,
                                  target_ident);
      end else begin
        e = expected_items.pop_front();
        if (item_kind !== e.kind || rebalance_needed !== e.need ||
            chosen_metric !== e.metric || task_kind !== e.tkind ||
            source_ident !== e.src || target_ident !== e.dst || last_item !== e.last) begin
          fails++;
          if (fails <= 10)
            $display("mismatch exp k%0d n%0d m%0d t%0d s%0d d%0d l%0d got k%0d n%0d m%0d t%0d s%0d d%0d l%0d",
                     e.kind, e.need, e.metric, e.tkind, e.src, e.dst, e.last,
                     item_kind, rebalance_needed, chosen_metric, task_kind,
                     source_ident, target_ident, last_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("cluster_load_rebalance_planner_core test failed");
      $finish;
    end
  end

  function automatic record_t mk(logic [15:0] id, logic [11:0] ld, logic [47:0] b,
                                 logic [31:0] q, logic f);
    record_t r;
    r = {id, ld, b, q, f};
    return r;
  endfunction

  // report with a random flavor: 0 wild, 1 data spread, 2 rate spread, 3 leaders
  task automatic queue_report(int n, int flavor);
    logic [11:0] lbase;
    logic [47:0] b;
    logic [31:0] q;
    lbase = 12'($urandom_range(4095));
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0: begin
          b = 48'({$urandom, $urandom});
          q = $urandom;
        end
        1: begin
          b = ($urandom_range(1)) ? 48'($urandom_range(100000, 60000)) :
                                    48'($urandom_range(30000));
          q = 32'd5000;
        end
        2: begin
          b = 48'd777;
          q = ($urandom_range(1)) ? $urandom_range(9000, 5000) : $urandom_range(2500);
        end
        default: begin
          b = 48'($urandom_range(3));
          q = $urandom_range(3);
        end
      endcase
      add_record(mk(16'($urandom), (flavor == 0 || flavor == 3) ?
                    12'($urandom) : lbase, b, q, i == n - 1));
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      clrp_pkg::REG_SPREAD: spread_lim = val[11:0];
      clrp_pkg::REG_RATIO: ratio = val;
      default: floor_rate = val;
    endcase
  endtask

  task automatic drain;
    wait (pending_records.size() == 0 && !in_valid && expected_items.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 15) : $urandom_range(1, 9);
      queue_report(n, $urandom_range(3));
      sent += n;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: lone node, zero and full nodes, leader spread, idle min cases, twelve-node data spread
    add_record(mk(16'h0001, 12'd5, 48'd10, 32'd10, 1));
    add_record(mk(16'h0000, 12'd0, 48'd0, 32'd0, 0));
    add_record(mk(16'hffff, 12'd0, 48'd0, 32'd0, 1));
    add_record(mk(16'hffff, 12'hfff, '1, '1, 0));
    add_record(mk(16'h8000, 12'hfff, '1, '1, 1));
    add_record(mk(16'd3, 12'd0, 48'd5, 32'd5, 0));
    add_record(mk(16'd4, 12'hfff, 48'd5, 32'd5, 1));
    add_record(mk(16'd5, 12'd1, 48'd0, 32'd9, 0));
    add_record(mk(16'd6, 12'd1, 48'd900, 32'd9, 0));
    add_record(mk(16'd7, 12'd1, 48'd300, 32'd9, 1));
    add_record(mk(16'd8, 12'd1, 48'd4, 32'd0, 0));
    add_record(mk(16'd9, 12'd1, 48'd4, 32'd101, 0));
    add_record(mk(16'd10, 12'd1, 48'd4, 32'd100, 1));
    for (int i = 0; i < 12; i++)
      add_record(mk(16'(100 + i), 12'd7, (i % 2) ? 48'd1000 : 48'd10,
                    32'd1, i == 11));
    drain();
    random_phase(80);
    drain();
    idle_pct = 65;
    write_reg(clrp_pkg::REG_SPREAD, 16'd0);
    write_reg(clrp_pkg::REG_RATIO, 16'd256);
    write_reg(clrp_pkg::REG_FLOOR, 16'd0);
    random_phase(80);
    drain();
    idle_pct = 0;
    stall_pct = 65;
    write_reg(clrp_pkg::REG_SPREAD, 16'd4095);
    write_reg(clrp_pkg::REG_RATIO, 16'd65535);
    write_reg(clrp_pkg::REG_FLOOR, 16'd65535);
    random_phase(70);
    drain();
    idle_pct = 14;
    stall_pct = 14;
    write_reg(clrp_pkg::REG_SPREAD, 16'($urandom_range(40)));
    write_reg(clrp_pkg::REG_RATIO, 16'($urandom_range(1024, 256)));
    write_reg(clrp_pkg::REG_FLOOR, 16'($urandom_range(3000)));
    random_phase(70);
    drain();
    write_reg(clrp_pkg::REG_RATIO, 16'($urandom_range(255)));
    random_phase(50);
    drain();
    if (fails == 0 && expected_items.size() == 0) begin
      $display("cluster_load_rebalance_planner_core test passed");
    end else begin
      $display("cluster_load_rebalance_planner_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/clrp_pkg.sv
sv/clrp_front.sv
sv/clrp_queue.sv
sv/clrp_back.sv
sv/cluster_load_rebalance_planner_core.sv
bench/tb_top.sv
